/* rtl/core/assert_macros.svh */
// assertion macros used by rtl/core/rro_corner.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/core/rro_pkg.sv */
// shared constants, types and tables of the rotated rectangle overlap test
package rro_pkg;

  localparam int TRIG_FRAC_BITS  = 16;
  localparam int COORD_BITS      = 15;
  localparam int SIZE_BITS       = COORD_BITS - 1;
  localparam int ANGLE_BITS      = 16;
  localparam int FULL_TURN       = 23040;
  localparam int HALF_TURN       = 11520;
  localparam int QUARTER_TURN    = 5760;
  localparam int DEG_SHIFT       = 10;
  localparam int CORDIC_STEPS    = 23;
  localparam longint CORDIC_GAIN_Q30 = 652032874;

  localparam int TW    = TRIG_FRAC_BITS + 2;
  localparam int XW    = TRIG_FRAC_BITS + 4;
  localparam int ZW    = 27;
  localparam int MID_W = COORD_BITS + 1;
  localparam int FX    = TRIG_FRAC_BITS + 1;
  localparam int CW    = MID_W + FX + 3;
  localparam int QW    = CW - FX;
  localparam int PW    = CW + 4;
  localparam int PRW   = TW + SIZE_BITS + 1;
  localparam int MHW   = TW + QW;
  localparam int MLW   = TW + FX + 1;
  localparam int BPW   = TW + MID_W;

  localparam int IN_W        = 4 * COORD_BITS + 4 * SIZE_BITS + ANGLE_BITS;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic signed [XW-1:0] CORDIC_X0 =
    XW'(CORDIC_GAIN_Q30 >>> (30 - TRIG_FRAC_BITS));

  localparam logic signed [ZW-1:0] ATAN_DEG [CORDIC_STEPS] = '{
    ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945), ZW'(234379),
    ZW'(117304), ZW'(58666), ZW'(29335), ZW'(14668), ZW'(7334), ZW'(3667),
    ZW'(1833), ZW'(917), ZW'(458), ZW'(229), ZW'(115), ZW'(57), ZW'(29),
    ZW'(14), ZW'(7), ZW'(4), ZW'(2), ZW'(1)
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rot_left;
    logic signed [COORD_BITS-1:0] rot_top;
    logic [SIZE_BITS-1:0]         rot_width;
    logic [SIZE_BITS-1:0]         rot_height;
    logic signed [COORD_BITS-1:0] box_left;
    logic signed [COORD_BITS-1:0] box_top;
    logic [SIZE_BITS-1:0]         box_width;
    logic [SIZE_BITS-1:0]         box_height;
  } geom_t;

  typedef struct packed {
    logic                 flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    geom_t                g;
  } cordic_t;

  typedef struct packed {
    logic signed [TW-1:0]    c;
    logic signed [TW-1:0]    s;
    logic [3:0][CW-1:0]      ax;
    logic [3:0][CW-1:0]      ay;
    logic signed [MID_W-1:0] bx0;
    logic signed [MID_W-1:0] bx1;
    logic signed [MID_W-1:0] by0;
    logic signed [MID_W-1:0] by1;
  } corner_t;

endpackage

/* rtl/core/rro_angle.sv */
// angle wrap to a half turn and fold to a quarter turn, cordic seed
module rro_angle
  import rro_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [ANGLE_BITS-1:0] in_angle,
  input  geom_t                        in_geom,
  output logic                         out_valid,
  output cordic_t                      out_st
);

  localparam logic signed [ANGLE_BITS:0] FULL_S = (ANGLE_BITS+1)'(FULL_TURN);
  localparam logic signed [ANGLE_BITS:0] HALF_S = (ANGLE_BITS+1)'(HALF_TURN);
  localparam logic signed [ANGLE_BITS-1:0] HALF_R = ANGLE_BITS'(HALF_TURN);
  localparam logic signed [ANGLE_BITS-1:0] QUARTER_R = ANGLE_BITS'(QUARTER_TURN);

  logic                         v1_r;
  logic                         v2_r;
  logic signed [ANGLE_BITS:0]   a_ext;
  logic signed [ANGLE_BITS-1:0] r1_r;
  logic signed [ANGLE_BITS-1:0] r1_nxt;
  logic signed [ANGLE_BITS-1:0] r2;
  geom_t                        g1_r;
  cordic_t                      st2_r;
  cordic_t                      st2_nxt;

  always_comb begin
    a_ext = (ANGLE_BITS+1)'(in_angle);
    if (a_ext >= HALF_S) begin
      r1_nxt = ANGLE_BITS'(a_ext - FULL_S);
    end else if (a_ext < -HALF_S) begin
      r1_nxt = ANGLE_BITS'(a_ext + FULL_S);
    end else begin
      r1_nxt = ANGLE_BITS'(a_ext);
    end
  end

  always_comb begin
    st2_nxt.g    = g1_r;
    st2_nxt.x    = CORDIC_X0;
    st2_nxt.y    = '0;
    st2_nxt.flip = 1'b0;
    r2           = r1_r;
    if (r1_r > QUARTER_R) begin
      r2           = r1_r - HALF_R;
      st2_nxt.flip = 1'b1;
    end else if (r1_r < -QUARTER_R) begin
      r2           = r1_r + HALF_R;
      st2_nxt.flip = 1'b1;
    end
    st2_nxt.z = ZW'(r2) <<< DEG_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r  <= r1_nxt;
      g1_r  <= in_geom;
      st2_r <= st2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_st    = st2_r;

endmodule

/* rtl/core/rro_cordic.sv */
// rotation-mode cordic, one iteration per pipeline stage
module rro_cordic
  import rro_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  cordic_t in_st,
  output logic    out_valid,
  output cordic_t out_st
);

  logic [CORDIC_STEPS-1:0] v_r;
  cordic_t                 st_r   [CORDIC_STEPS];
  cordic_t                 st_in  [CORDIC_STEPS];
  cordic_t                 st_nxt [CORDIC_STEPS];
  logic signed [XW-1:0]    dx     [CORDIC_STEPS];
  logic signed [XW-1:0]    dy     [CORDIC_STEPS];

  always_comb begin
    st_in[0] = in_st;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      st_in[i] = st_r[i-1];
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx[i]     = $signed(st_in[i].y) >>> i;
      dy[i]     = $signed(st_in[i].x) >>> i;
      st_nxt[i] = st_in[i];
      if (!st_in[i].z[ZW-1]) begin
        st_nxt[i].x = st_in[i].x - dx[i];
        st_nxt[i].y = st_in[i].y + dy[i];
        st_nxt[i].z = st_in[i].z - ATAN_DEG[i];
      end else begin
        st_nxt[i].x = st_in[i].x + dx[i];
        st_nxt[i].y = st_in[i].y - dy[i];
        st_nxt[i].z = st_in[i].z + ATAN_DEG[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[CORDIC_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_valid = v_r[CORDIC_STEPS-1];
  assign out_st    = st_r[CORDIC_STEPS-1];

endmodule

/* rtl/core/rro_corner.sv */
// sign fix and clamp of cos and sin, half extents, rotated and box corners
`include "assert_macros.svh"

module rro_corner
  import rro_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  cordic_t in_st,
  output logic    out_valid,
  output corner_t out_cn
);

  localparam logic signed [XW-1:0] ONE_X = XW'(longint'(1) << TRIG_FRAC_BITS);
  localparam logic signed [TW-1:0] ONE_T = TW'(longint'(1) << TRIG_FRAC_BITS);

  logic                    v1_r;
  logic                    v2_r;
  logic                    v3_r;
  logic signed [XW-1:0]    xs;
  logic signed [XW-1:0]    ys;
  logic signed [TW-1:0]    c1_nxt;
  logic signed [TW-1:0]    s1_nxt;
  logic signed [TW-1:0]    c1_r;
  logic signed [TW-1:0]    s1_r;
  logic signed [MID_W-1:0] mx1_r;
  logic signed [MID_W-1:0] my1_r;
  logic [SIZE_BITS-1:0]    rw1_r;
  logic [SIZE_BITS-1:0]    rh1_r;
  logic signed [MID_W-1:0] bx0_1_r;
  logic signed [MID_W-1:0] bx1_1_r;
  logic signed [MID_W-1:0] by0_1_r;
  logic signed [MID_W-1:0] by1_1_r;
  logic signed [TW-1:0]    c2_r;
  logic signed [TW-1:0]    s2_r;
  logic signed [MID_W-1:0] mx2_r;
  logic signed [MID_W-1:0] my2_r;
  logic signed [PRW-1:0]   hwx_r;
  logic signed [PRW-1:0]   hwy_r;
  logic signed [PRW-1:0]   hhx_r;
  logic signed [PRW-1:0]   hhy_r;
  logic signed [MID_W-1:0] bx0_2_r;
  logic signed [MID_W-1:0] bx1_2_r;
  logic signed [MID_W-1:0] by0_2_r;
  logic signed [MID_W-1:0] by1_2_r;
  logic signed [CW-1:0]    cxs;
  logic signed [CW-1:0]    cys;
  corner_t                 cn3_nxt;
  corner_t                 cn3_r;
  logic                    trig_in_range;

  always_comb begin
    xs = in_st.flip ? -in_st.x : in_st.x;
    ys = in_st.flip ? -in_st.y : in_st.y;
    if (xs > ONE_X) begin
      c1_nxt = ONE_T;
    end else if (xs < -ONE_X) begin
      c1_nxt = -ONE_T;
    end else begin
      c1_nxt = TW'(xs);
    end
    if (ys > ONE_X) begin
      s1_nxt = ONE_T;
    end else if (ys < -ONE_X) begin
      s1_nxt = -ONE_T;
    end else begin
      s1_nxt = TW'(ys);
    end
  end

  always_comb begin
    cxs = CW'(mx2_r) <<< FX;
    cys = CW'(my2_r) <<< FX;
    cn3_nxt.c     = c2_r;
    cn3_nxt.s     = s2_r;
    cn3_nxt.ax[0] = cxs - CW'(hwx_r) - CW'(hhx_r);
    cn3_nxt.ay[0] = cys - CW'(hwy_r) - CW'(hhy_r);
    cn3_nxt.ax[1] = cxs + CW'(hwx_r) - CW'(hhx_r);
    cn3_nxt.ay[1] = cys + CW'(hwy_r) - CW'(hhy_r);
    cn3_nxt.ax[2] = cxs + CW'(hwx_r) + CW'(hhx_r);
    cn3_nxt.ay[2] = cys + CW'(hwy_r) + CW'(hhy_r);
    cn3_nxt.ax[3] = cxs - CW'(hwx_r) + CW'(hhx_r);
    cn3_nxt.ay[3] = cys - CW'(hwy_r) + CW'(hhy_r);
    cn3_nxt.bx0   = bx0_2_r;
    cn3_nxt.bx1   = bx1_2_r;
    cn3_nxt.by0   = by0_2_r;
    cn3_nxt.by1   = by1_2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r    <= c1_nxt;
      s1_r    <= s1_nxt;
      mx1_r   <= MID_W'(in_st.g.rot_left)
                 + MID_W'(in_st.g.rot_width[SIZE_BITS-1:1]);
      my1_r   <= MID_W'(in_st.g.rot_top)
                 + MID_W'(in_st.g.rot_height[SIZE_BITS-1:1]);
      rw1_r   <= in_st.g.rot_width;
      rh1_r   <= in_st.g.rot_height;
      bx0_1_r <= MID_W'(in_st.g.box_left);
      bx1_1_r <= MID_W'(in_st.g.box_left) + MID_W'(in_st.g.box_width);
      by0_1_r <= MID_W'(in_st.g.box_top);
      by1_1_r <= MID_W'(in_st.g.box_top) + MID_W'(in_st.g.box_height);

      c2_r    <= c1_r;
      s2_r    <= s1_r;
      mx2_r   <= mx1_r;
      my2_r   <= my1_r;
      hwx_r   <= PRW'(c1_r) * PRW'($signed({1'b0, rw1_r}));
      hwy_r   <= PRW'(s1_r) * PRW'($signed({1'b0, rw1_r}));
      hhx_r   <= -(PRW'(s1_r) * PRW'($signed({1'b0, rh1_r})));
      hhy_r   <= PRW'(c1_r) * PRW'($signed({1'b0, rh1_r}));
      bx0_2_r <= bx0_1_r;
      bx1_2_r <= bx1_1_r;
      by0_2_r <= by0_1_r;
      by1_2_r <= by1_1_r;

      cn3_r   <= cn3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_cn    = cn3_r;

  assign trig_in_range = (c1_r <= ONE_T) && (c1_r >= -ONE_T)
                         && (s1_r <= ONE_T) && (s1_r >= -ONE_T);

  `ASSERT_NXT(a_valid_advance, clk, rst_n, v1_r && en, v2_r)
  `ASSERT_NXT(a_valid_hold, clk, rst_n, !en && v2_r, v2_r && $stable(hwx_r))
  `ASSERT_IMP(a_trig_clamped, clk, rst_n, v1_r, trig_in_range)

endmodule

/* rtl/core/rro_project.sv */
// projections on the four axes, extents and separation decision
module rro_project
  import rro_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  corner_t in_cn,
  output logic    out_valid,
  output logic    out_overlap
);

  logic                    v_r [6];
  logic signed [TW-1:0]    ca [2];
  logic signed [TW-1:0]    cb [2];
  logic signed [QW-1:0]    xq [4];
  logic signed [QW-1:0]    yq [4];
  logic signed [FX:0]      xr [4];
  logic signed [FX:0]      yr [4];
  logic signed [MHW-1:0]   mhx_r [2][4];
  logic signed [MHW-1:0]   mhy_r [2][4];
  logic signed [MLW-1:0]   mlx_r [2][4];
  logic signed [MLW-1:0]   mly_r [2][4];
  logic signed [BPW-1:0]   bpx_r [2][2];
  logic signed [BPW-1:0]   bpy_r [2][2];
  logic signed [CW-1:0]    ax1_r [4];
  logic signed [CW-1:0]    ay1_r [4];
  logic signed [MID_W-1:0] b1_r [4];
  logic signed [MLW:0]     lsum [2][4];
  logic signed [PW-1:0]    hi2_r [2][4];
  logic signed [PW-1:0]    lo2_r [2][4];
  logic signed [PW-1:0]    pb2_r [2][4];
  logic signed [CW-1:0]    ax2_r [4];
  logic signed [CW-1:0]    ay2_r [4];
  logic signed [MID_W-1:0] b2_r [4];
  logic signed [PW-1:0]    pa3_r [4][4];
  logic signed [PW-1:0]    pb3_r [4][4];
  logic signed [PW-1:0]    mna4_r [4][2];
  logic signed [PW-1:0]    mxa4_r [4][2];
  logic signed [PW-1:0]    mnb4_r [4][2];
  logic signed [PW-1:0]    mxb4_r [4][2];
  logic signed [PW-1:0]    mna5_r [4];
  logic signed [PW-1:0]    mxa5_r [4];
  logic signed [PW-1:0]    mnb5_r [4];
  logic signed [PW-1:0]    mxb5_r [4];
  logic [3:0]              sep;
  logic                    overlap_r;

  always_comb begin
    ca[0] = in_cn.c;
    cb[0] = in_cn.s;
    ca[1] = -in_cn.s;
    cb[1] = in_cn.c;
    for (int i = 0; i < 4; i++) begin
      xq[i] = $signed(in_cn.ax[i][CW-1:FX]);
      yq[i] = $signed(in_cn.ay[i][CW-1:FX]);
      xr[i] = $signed({1'b0, in_cn.ax[i][FX-1:0]});
      yr[i] = $signed({1'b0, in_cn.ay[i][FX-1:0]});
    end
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 4; i++) begin
        lsum[k][i] = (MLW+1)'(mlx_r[k][i]) + (MLW+1)'(mly_r[k][i]);
      end
    end
    for (int a = 0; a < 4; a++) begin
      sep[a] = (mxa5_r[a] < mnb5_r[a]) || (mxb5_r[a] < mna5_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 6; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int j = 1; j < 6; j++) begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 4; i++) begin
          mhx_r[k][i] <= MHW'(ca[k]) * MHW'(xq[i]);
          mhy_r[k][i] <= MHW'(cb[k]) * MHW'(yq[i]);
          mlx_r[k][i] <= MLW'(ca[k]) * MLW'(xr[i]);
          mly_r[k][i] <= MLW'(cb[k]) * MLW'(yr[i]);
        end
        bpx_r[k][0] <= BPW'(ca[k]) * BPW'(in_cn.bx0);
        bpx_r[k][1] <= BPW'(ca[k]) * BPW'(in_cn.bx1);
        bpy_r[k][0] <= BPW'(cb[k]) * BPW'(in_cn.by0);
        bpy_r[k][1] <= BPW'(cb[k]) * BPW'(in_cn.by1);
      end
      for (int i = 0; i < 4; i++) begin
        ax1_r[i] <= $signed(in_cn.ax[i]);
        ay1_r[i] <= $signed(in_cn.ay[i]);
      end
      b1_r[0] <= in_cn.bx0;
      b1_r[1] <= in_cn.bx1;
      b1_r[2] <= in_cn.by0;
      b1_r[3] <= in_cn.by1;

      // sums of products
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 4; i++) begin
          hi2_r[k][i] <= PW'(mhx_r[k][i]) + PW'(mhy_r[k][i]);
          lo2_r[k][i] <= PW'(lsum[k][i] >>> FX);
        end
        pb2_r[k][0] <= PW'(bpx_r[k][0]) + PW'(bpy_r[k][0]);
        pb2_r[k][1] <= PW'(bpx_r[k][1]) + PW'(bpy_r[k][0]);
        pb2_r[k][2] <= PW'(bpx_r[k][1]) + PW'(bpy_r[k][1]);
        pb2_r[k][3] <= PW'(bpx_r[k][0]) + PW'(bpy_r[k][1]);
      end
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      b2_r  <= b1_r;

      // projections on x, y and the two rotated axes
      for (int i = 0; i < 4; i++) begin
        pa3_r[0][i] <= PW'(ax2_r[i]);
        pa3_r[1][i] <= PW'(ay2_r[i]);
        pa3_r[2][i] <= hi2_r[0][i] + lo2_r[0][i];
        pa3_r[3][i] <= hi2_r[1][i] + lo2_r[1][i];
        pb3_r[2][i] <= pb2_r[0][i];
        pb3_r[3][i] <= pb2_r[1][i];
      end
      pb3_r[0][0] <= PW'(b2_r[0]) <<< FX;
      pb3_r[0][1] <= PW'(b2_r[1]) <<< FX;
      pb3_r[0][2] <= PW'(b2_r[1]) <<< FX;
      pb3_r[0][3] <= PW'(b2_r[0]) <<< FX;
      pb3_r[1][0] <= PW'(b2_r[2]) <<< FX;
      pb3_r[1][1] <= PW'(b2_r[2]) <<< FX;
      pb3_r[1][2] <= PW'(b2_r[3]) <<< FX;
      pb3_r[1][3] <= PW'(b2_r[3]) <<< FX;

      // extents, two levels
      for (int a = 0; a < 4; a++) begin
        for (int h = 0; h < 2; h++) begin
          mna4_r[a][h] <= (pa3_r[a][2*h] < pa3_r[a][2*h+1]) ?
                          pa3_r[a][2*h] : pa3_r[a][2*h+1];
          mxa4_r[a][h] <= (pa3_r[a][2*h] > pa3_r[a][2*h+1]) ?
                          pa3_r[a][2*h] : pa3_r[a][2*h+1];
          mnb4_r[a][h] <= (pb3_r[a][2*h] < pb3_r[a][2*h+1]) ?
                          pb3_r[a][2*h] : pb3_r[a][2*h+1];
          mxb4_r[a][h] <= (pb3_r[a][2*h] > pb3_r[a][2*h+1]) ?
                          pb3_r[a][2*h] : pb3_r[a][2*h+1];
        end
        mna5_r[a] <= (mna4_r[a][0] < mna4_r[a][1]) ? mna4_r[a][0] : mna4_r[a][1];
        mxa5_r[a] <= (mxa4_r[a][0] > mxa4_r[a][1]) ? mxa4_r[a][0] : mxa4_r[a][1];
        mnb5_r[a] <= (mnb4_r[a][0] < mnb4_r[a][1]) ? mnb4_r[a][0] : mnb4_r[a][1];
        mxb5_r[a] <= (mxb4_r[a][0] > mxb4_r[a][1]) ? mxb4_r[a][0] : mxb4_r[a][1];
      end

      overlap_r <= ~(|sep);
    end
  end

  assign out_valid   = v_r[5];
  assign out_overlap = overlap_r;

endmodule

/* rtl/core/rotated_rect_overlap_test.sv */
// top level of the rotated rectangle versus box overlap test
// throughput: one transaction per cycle, set by the fully pipelined cordic and
// projection stages; the whole pipeline holds while a result waits on out_tready
// reset: synchronous active-low rst_n clears all stage valid bits, no clearing pass
module rotated_rect_overlap_test
  import rro_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // rot_left, rot_top, rot_width, rot_height, turn_angle,
  // box_left, box_top, box_width, box_height, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // overlap, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int O_RT = COORD_BITS;
  localparam int O_RW = 2 * COORD_BITS;
  localparam int O_RH = O_RW + SIZE_BITS;
  localparam int O_AN = O_RH + SIZE_BITS;
  localparam int O_BL = O_AN + ANGLE_BITS;
  localparam int O_BT = O_BL + COORD_BITS;
  localparam int O_BW = O_BT + COORD_BITS;
  localparam int O_BH = O_BW + SIZE_BITS;

  logic                         en;
  geom_t                        geom;
  logic signed [ANGLE_BITS-1:0] angle;
  logic                         ang_valid;
  cordic_t                      ang_st;
  logic                         cor_valid;
  cordic_t                      cor_st;
  logic                         cn_valid;
  corner_t                      cn;
  logic                         overlap;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    geom.rot_left   = $signed(in_tdata[O_RT-1:0]);
    geom.rot_top    = $signed(in_tdata[O_RW-1:O_RT]);
    geom.rot_width  = in_tdata[O_RH-1:O_RW];
    geom.rot_height = in_tdata[O_AN-1:O_RH];
    angle           = $signed(in_tdata[O_BL-1:O_AN]);
    geom.box_left   = $signed(in_tdata[O_BT-1:O_BL]);
    geom.box_top    = $signed(in_tdata[O_BW-1:O_BT]);
    geom.box_width  = in_tdata[O_BH-1:O_BW];
    geom.box_height = in_tdata[IN_W-1:O_BH];
  end

  rro_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_angle  (angle),
    .in_geom   (geom),
    .out_valid (ang_valid),
    .out_st    (ang_st)
  );

  rro_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ang_valid),
    .in_st     (ang_st),
    .out_valid (cor_valid),
    .out_st    (cor_st)
  );

  rro_corner u_corner (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cor_valid),
    .in_st     (cor_st),
    .out_valid (cn_valid),
    .out_cn    (cn)
  );

  rro_project u_project (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (cn_valid),
    .in_cn       (cn),
    .out_valid   (out_tvalid),
    .out_overlap (overlap)
  );

  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, overlap};

endmodule
